// File: sv/l2c_pkg.sv
// Shared types, codes and field widths of the LBA to CHS translator.
package l2c_pkg;

   localparam int LBA_W       = 32;
   localparam int CYL_W       = 10;
   localparam int HEAD_W      = 4;
   localparam int SECT_W      = 8;
   localparam int HC_W        = 5;
   localparam int PROD_W      = 12;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [HC_W-1:0]   HEAD_LIMIT       = 5'd16;
   localparam logic [HC_W-1:0]   HEAD_COUNT_RESET = 5'd16;
   localparam logic [SECT_W-1:0] SPT_RESET        = 8'd63;
   localparam logic [LBA_W-1:0]  TOTAL_RESET      = 32'd0;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_CYL   = 2'd2,
      ST_GEOM  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOTAL_SECTORS     = 2'd0,
      CSR_HEAD_COUNT        = 2'd1,
      CSR_SECTORS_PER_TRACK = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LBA_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status_code;
      logic [CYL_W-1:0]    cylinder;
      logic [HEAD_W-1:0]   head;
      logic [SECT_W-1:0]   sector;
   } rsp_type;

   typedef struct packed {
      logic                  en;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   typedef struct packed {
      logic [PROD_W-1:0] per_cyl;
      logic [SECT_W-1:0] spt;
   } geom_type;

   typedef struct packed {
      status_type       status;
      logic [LBA_W-1:0] lba;
   } entry_type;

endpackage

// File: sv/l2c_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
interface l2c_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/lba_to_chs_translator_top.sv
// Top level: LBA to CHS translator, front end, queue and divider back end.
// Throughput: one address per cycle, sustained while the result side takes a beat every cycle.
// Pipeline: two intake stages and the queue, then one divider stage per cylinder bit, four for the head,
//   one output.
// Reset: synchronous, active high; clears all valid flags and the queue, loads the geometry
//   registers with capacity 0, 16 heads and 63 sectors per track.
module lba_to_chs_translator_top #(
   parameter int MAX_CYLINDER = 1023,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [l2c_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [l2c_pkg::CSR_DATA_W-1:0]    csr_write_data,
   l2c_stream_if.sink                        req_stream,
   l2c_stream_if.source                      rsp_stream
);

   // quotient width of the cylinder divider; cylinders beyond the limit pass through it tagged as faults
   localparam int QUO_W   = $clog2(MAX_CYLINDER + 1);
   localparam int ENTRY_W = $bits(l2c_pkg::entry_type);

   l2c_pkg::csr_write_type csr;
   l2c_pkg::geom_type      geom;
   l2c_pkg::entry_type     push_entry;
   l2c_pkg::entry_type     head_entry;
   logic                   push;
   logic                   pop;
   logic                   queue_full;
   logic                   queue_empty;

   assign csr.en    = csr_write_enable;
   assign csr.index = csr_index;
   assign csr.data  = csr_write_data;

   // front: holds the geometry, registers each request beat and tags it with a status
   l2c_front #(
      .MAX_CYLINDER (MAX_CYLINDER)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .req_stream (req_stream),
      .push_entry (push_entry),
      .push       (push),
      .queue_full (queue_full),
      .geom       (geom)
   );

   // queue: lets the front keep taking beats while the back end is stalled
   l2c_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (push_entry),
      .full    (queue_full),
      .rd_en   (pop),
      .rd_data (head_entry),
      .empty   (queue_empty)
   );

   // back: divides through the pipeline and presents the result beat
   l2c_back #(
      .QUO_W (QUO_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .head_entry (head_entry),
      .head_valid (!queue_empty),
      .pop        (pop),
      .rsp_stream (rsp_stream)
   );

   // a faulted result carries no coordinates
   assert property (@(posedge clock) disable iff (reset)
      rsp_stream.valid && (rsp_stream.payload.status_code != l2c_pkg::ST_OK) |->
         (rsp_stream.payload.cylinder == '0) && (rsp_stream.payload.head == '0) &&
         (rsp_stream.payload.sector == '0))
      else $error("faulted result with nonzero coordinates");

   // a good result has a sector within the track
   assert property (@(posedge clock) disable iff (reset)
      rsp_stream.valid && (rsp_stream.payload.status_code == l2c_pkg::ST_OK) |->
         (rsp_stream.payload.sector != '0) && (rsp_stream.payload.sector <= geom.spt))
      else $error("sector out of track range");

   // a good result never exceeds the cylinder limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_stream.valid && (rsp_stream.payload.status_code == l2c_pkg::ST_OK) |->
         (32'(rsp_stream.payload.cylinder) <= 32'(MAX_CYLINDER)))
      else $error("cylinder above limit passed as good");

endmodule

// File: sv/l2c_front.sv
// Front end: configuration registers, address intake and fault classification.
module l2c_front #(
   parameter int MAX_CYLINDER = 1023
) (
   input  logic                   clock,
   input  logic                   reset,
   input  l2c_pkg::csr_write_type csr,
   l2c_stream_if.sink             req_stream,
   output l2c_pkg::entry_type     push_entry,
   output logic                   push,
   input  logic                   queue_full,
   output l2c_pkg::geom_type      geom
);

   localparam int QUO_W = $clog2(MAX_CYLINDER + 1);
   localparam int LIM_W = QUO_W + l2c_pkg::PROD_W;

   logic [l2c_pkg::LBA_W-1:0]  total_ff;
   logic [l2c_pkg::HC_W-1:0]   head_count_ff;
   logic [l2c_pkg::SECT_W-1:0] spt_ff;
   logic [l2c_pkg::PROD_W-1:0] per_cyl_ff, per_cyl_in;
   logic [LIM_W-1:0]           limit_ff, limit_in;
   logic                       geom_bad_ff, geom_bad_in;

   logic                       s0_valid_ff, s1_valid_ff;
   logic [l2c_pkg::LBA_W-1:0]  s0_lba_ff, s1_lba_ff;
   logic                       s1_range_ff, s1_range_in;
   logic                       advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= l2c_pkg::TOTAL_RESET;
         head_count_ff <= l2c_pkg::HEAD_COUNT_RESET;
         spt_ff        <= l2c_pkg::SPT_RESET;
      end else if (csr.en) begin
         case (csr.index)
            l2c_pkg::CSR_TOTAL_SECTORS:     total_ff      <= csr.data;
            l2c_pkg::CSR_HEAD_COUNT:        head_count_ff <= csr.data[l2c_pkg::HC_W-1:0];
            l2c_pkg::CSR_SECTORS_PER_TRACK: spt_ff        <= csr.data[l2c_pkg::SECT_W-1:0];
            default: ;
         endcase
      end
   end

   // derived geometry, registered in turn: sectors per cylinder, then the address limit from it
   assign per_cyl_in  = l2c_pkg::PROD_W'(head_count_ff) * l2c_pkg::PROD_W'(spt_ff);
   assign limit_in    = LIM_W'(per_cyl_ff) * LIM_W'(MAX_CYLINDER + 1);
   assign geom_bad_in = (head_count_ff == '0) || (spt_ff == '0) ||
                        (head_count_ff > l2c_pkg::HEAD_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         per_cyl_ff  <= l2c_pkg::PROD_W'(int'(l2c_pkg::HEAD_COUNT_RESET) *
                                         int'(l2c_pkg::SPT_RESET));
         limit_ff    <= LIM_W'((MAX_CYLINDER + 1) * int'(l2c_pkg::HEAD_COUNT_RESET) *
                               int'(l2c_pkg::SPT_RESET));
         geom_bad_ff <= 1'b0;
      end else begin
         per_cyl_ff  <= per_cyl_in;
         limit_ff    <= limit_in;
         geom_bad_ff <= geom_bad_in;
      end
   end

   // two intake stages, both hold while the queue is full and the second stage holds a beat
   assign advance          = !s1_valid_ff || !queue_full;
   assign req_stream.ready = advance;
   assign s1_range_in      = s0_lba_ff >= total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_stream.valid;
         s1_valid_ff <= s0_valid_ff;
      end
      if (advance) begin
         s0_lba_ff   <= req_stream.payload.block_address;
         s1_lba_ff   <= s0_lba_ff;
         s1_range_ff <= s1_range_in;
      end
   end

   // capacity first, then geometry, then cylinder limit
   always_comb begin
      push_entry.lba = s1_lba_ff;
      if (s1_range_ff)
         push_entry.status = l2c_pkg::ST_RANGE;
      else if (geom_bad_ff)
         push_entry.status = l2c_pkg::ST_GEOM;
      else if (s1_lba_ff >= l2c_pkg::LBA_W'(limit_ff))
         push_entry.status = l2c_pkg::ST_CYL;
      else
         push_entry.status = l2c_pkg::ST_OK;
   end

   assign push         = s1_valid_ff && !queue_full;
   assign geom.per_cyl = per_cyl_ff;
   assign geom.spt     = spt_ff;

endmodule

// File: sv/l2c_queue.sv
// Small register FIFO between front and back end.
module l2c_queue #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (rd_en)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (wr_en && !rd_en)
         count_in = count_ff + 1'b1;
      else if (rd_en && !wr_en)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (wr_en)
         mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

// File: sv/l2c_back.sv
// Back end: pipelined restoring division into cylinder, head and sector.
module l2c_back #(
   parameter int QUO_W = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  l2c_pkg::geom_type  geom,
   input  l2c_pkg::entry_type head_entry,
   input  logic               head_valid,
   output logic               pop,
   l2c_stream_if.source       rsp_stream
);

   localparam int LBA_W  = l2c_pkg::LBA_W;
   localparam int PROD_W = l2c_pkg::PROD_W;
   localparam int HEAD_W = l2c_pkg::HEAD_W;
   localparam int CYL_W  = l2c_pkg::CYL_W;
   localparam int QX_W   = (QUO_W > CYL_W) ? QUO_W : CYL_W;

   typedef struct packed {
      logic               valid;
      l2c_pkg::status_type status;
      logic [LBA_W-1:0]   rem;
      logic [QUO_W-1:0]   quo;
   } cstage_type;

   typedef struct packed {
      logic               valid;
      l2c_pkg::status_type status;
      logic [CYL_W-1:0]   cyl;
      logic [PROD_W-1:0]  rem;
      logic [HEAD_W-1:0]  hd;
   } hstage_type;

   cstage_type        c_ff  [QUO_W];
   cstage_type        c_src [QUO_W];
   hstage_type        h_ff  [HEAD_W];
   hstage_type        h_src [HEAD_W];
   logic              o_valid_ff;
   l2c_pkg::rsp_type  o_payload_ff, o_payload_in;
   logic [QX_W-1:0]   quo_ext;
   logic              advance;

   // whole pipeline holds while the result register is stalled
   assign advance = !o_valid_ff || rsp_stream.ready;
   assign pop     = advance && head_valid;

   // one quotient bit of the cylinder per stage, most significant first
   for (genvar k = 0; k < QUO_W; k++) begin : g_cyl
      localparam int SH = QUO_W - 1 - k;
      logic [LBA_W-1:0] dvs;
      logic             ge;

      if (k == 0) begin : g_first
         assign c_src[k].valid  = head_valid;
         assign c_src[k].status = head_entry.status;
         assign c_src[k].rem    = head_entry.lba;
         assign c_src[k].quo    = '0;
      end else begin : g_next
         assign c_src[k] = c_ff[k-1];
      end

      assign dvs = LBA_W'(geom.per_cyl) << SH;
      assign ge  = c_src[k].rem >= dvs;

      always_ff @(posedge clock) begin
         if (reset)
            c_ff[k].valid <= 1'b0;
         else if (advance)
            c_ff[k].valid <= c_src[k].valid;
         if (advance) begin
            c_ff[k].status <= c_src[k].status;
            c_ff[k].rem    <= ge ? c_src[k].rem - dvs : c_src[k].rem;
            c_ff[k].quo    <= {c_src[k].quo[QUO_W-2:0], ge};
         end
      end
   end

   assign quo_ext = QX_W'(c_ff[QUO_W-1].quo);

   // head: remainder within the cylinder divided by sectors per track
   for (genvar j = 0; j < HEAD_W; j++) begin : g_head
      localparam int SH = HEAD_W - 1 - j;
      logic [PROD_W-1:0] dvs;
      logic              ge;

      if (j == 0) begin : g_first
         assign h_src[j].valid  = c_ff[QUO_W-1].valid;
         assign h_src[j].status = c_ff[QUO_W-1].status;
         assign h_src[j].cyl    = quo_ext[CYL_W-1:0];
         assign h_src[j].rem    = c_ff[QUO_W-1].rem[PROD_W-1:0];
         assign h_src[j].hd     = '0;
      end else begin : g_next
         assign h_src[j] = h_ff[j-1];
      end

      assign dvs = PROD_W'(geom.spt) << SH;
      assign ge  = h_src[j].rem >= dvs;

      always_ff @(posedge clock) begin
         if (reset)
            h_ff[j].valid <= 1'b0;
         else if (advance)
            h_ff[j].valid <= h_src[j].valid;
         if (advance) begin
            h_ff[j].status <= h_src[j].status;
            h_ff[j].cyl    <= h_src[j].cyl;
            h_ff[j].rem    <= ge ? h_src[j].rem - dvs : h_src[j].rem;
            h_ff[j].hd     <= {h_src[j].hd[HEAD_W-2:0], ge};
         end
      end
   end

   // drop coordinates on any fault
   always_comb begin
      o_payload_in.status_code = h_ff[HEAD_W-1].status;
      if (h_ff[HEAD_W-1].status == l2c_pkg::ST_OK) begin
         o_payload_in.cylinder = h_ff[HEAD_W-1].cyl;
         o_payload_in.head     = h_ff[HEAD_W-1].hd;
         o_payload_in.sector   = h_ff[HEAD_W-1].rem[l2c_pkg::SECT_W-1:0] + 1'b1;
      end else begin
         o_payload_in.cylinder = '0;
         o_payload_in.head     = '0;
         o_payload_in.sector   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         o_valid_ff <= 1'b0;
      else if (advance)
         o_valid_ff <= h_ff[HEAD_W-1].valid;
      if (advance)
         o_payload_ff <= o_payload_in;
   end

   assign rsp_stream.valid   = o_valid_ff;
   assign rsp_stream.payload = o_payload_ff;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench of the LBA to CHS translator top level.
`timescale 1ns / 100ps

module testbench;

   // Geometry limit of the instance and the pipeline depth of the top level.
   localparam int MAX_CYL       = 1023;
   localparam int PIPE_LATENCY  = $clog2(MAX_CYL + 1) + 8;
   // Longest run of cycles with no beat on either side before the run is declared hung.
   // The long receiver hold-off, HOLD_CYCLES, stays well below this; everything else is far shorter.
   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 300;

   logic                           clock;
   logic                           reset;
   logic                           csr_write_enable;
   logic [l2c_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [l2c_pkg::CSR_DATA_W-1:0] csr_write_data;

   l2c_stream_if #(.payload_type(l2c_pkg::req_type)) req_if ();
   l2c_stream_if #(.payload_type(l2c_pkg::rsp_type)) rsp_if ();

   lba_to_chs_translator_top #(
      .MAX_CYLINDER (MAX_CYL)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_stream       (req_if),
      .rsp_stream       (rsp_if)
   );

   // Local copy of the geometry registers, mirrored on every write.
   logic [l2c_pkg::LBA_W-1:0]  geo_total;
   logic [l2c_pkg::HC_W-1:0]   geo_heads;
   logic [l2c_pkg::SECT_W-1:0] geo_spt;

   // Translations accepted by the block and not yet returned, oldest first.
   l2c_pkg::rsp_type expected_chs[$];
   int               errors       = 0;
   int               quiet_cycles = 0;

   // Idle controls: sender gaps, receiver stalls, and a one-shot long hold-off request.
   bit send_gaps;
   bit recv_stalls;
   int hold_request = 0;
   bit hold_taken   = 1'b0;
   int stall_left   = 0;

   always #4 clock = ~clock;

   // Translate one address with the current geometry; faults zero all coordinates.
   function automatic l2c_pkg::rsp_type predict_chs(logic [l2c_pkg::LBA_W-1:0] lba);
      l2c_pkg::rsp_type r;
      longint unsigned  per_cyl;
      longint unsigned  cyl;
      longint unsigned  rem;
      longint unsigned  hd;
      r = '0;
      if (lba >= geo_total) begin
         r.status_code = l2c_pkg::ST_RANGE;
      end else if (geo_heads == 0 || geo_spt == 0 || geo_heads > l2c_pkg::HEAD_LIMIT) begin
         r.status_code = l2c_pkg::ST_GEOM;
      end else begin
         per_cyl = 64'(geo_heads) * 64'(geo_spt);
         cyl     = 64'(lba) / per_cyl;
         if (cyl > MAX_CYL) begin
            r.status_code = l2c_pkg::ST_CYL;
         end else begin
            rem           = 64'(lba) - cyl * per_cyl;
            hd            = rem / 64'(geo_spt);
            r.status_code = l2c_pkg::ST_OK;
            r.cylinder    = cyl[l2c_pkg::CYL_W-1:0];
            r.head        = hd[l2c_pkg::HEAD_W-1:0];
            r.sector      = l2c_pkg::SECT_W'(rem - hd * 64'(geo_spt) + 1);
         end
      end
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Compare every result beat with the oldest pending translation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_chs.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat: expected none, actual %h",
                     $time, rsp_if.payload);
         end else begin
            check_field("status_code", expected_chs[0].status_code, rsp_if.payload.status_code);
            check_field("cylinder", expected_chs[0].cylinder, rsp_if.payload.cylinder);
            check_field("head", expected_chs[0].head, rsp_if.payload.head);
            check_field("sector", expected_chs[0].sector, rsp_if.payload.sector);
            void'(expected_chs.pop_front());
         end
      end
   end

   // Watchdog: count cycles with no beat on either channel and stop a hung run.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Receiver: take a pending long hold-off first, else stall in short random bursts.
   always @(negedge clock) begin
      if (hold_request > 0 && !hold_taken) begin
         stall_left = hold_request;
         hold_taken = 1'b1;
      end
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
         stall_left   = $urandom_range(1, 19) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Offer one address and hold it until the block takes the beat. Entered and left at a
   // falling edge; valid stays high on exit so back-to-back beats need no gap.
   task automatic send_lba(input logic [l2c_pkg::LBA_W-1:0] lba);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_if.valid                 <= 1'b1;
      req_if.payload.block_address <= lba;
      do @(posedge clock); while (!req_if.ready);
      expected_chs.push_back(predict_chs(lba));
      @(negedge clock);
   endtask

   // Drop valid, drain every pending result, then let the pipeline run empty.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_chs.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 4) @(negedge clock);
   endtask

   // Write all three geometry registers on consecutive cycles; call only while idle.
   task automatic set_geometry(input logic [31:0] total, input logic [31:0] heads_data,
                               input logic [31:0] spt_data);
      csr_write_enable <= 1'b1;
      csr_index        <= l2c_pkg::CSR_TOTAL_SECTORS;
      csr_write_data   <= total;
      geo_total         = total;
      @(negedge clock);
      csr_index        <= l2c_pkg::CSR_HEAD_COUNT;
      csr_write_data   <= heads_data;
      geo_heads         = heads_data[l2c_pkg::HC_W-1:0];
      @(negedge clock);
      csr_index        <= l2c_pkg::CSR_SECTORS_PER_TRACK;
      csr_write_data   <= spt_data;
      geo_spt           = spt_data[l2c_pkg::SECT_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Reset geometry first (capacity zero rejects everything), then the default
   // 16 x 63 geometry at full capacity, across the cylinder limit and the top address.
   task automatic test_default_geometry();
      send_lba(32'd0);
      send_lba(32'hFFFF_FFFF);
      wait_idle();
      set_geometry(32'hFFFF_FFFF, 32'd16, 32'd63);
      send_lba(32'd0);
      send_lba(32'd62);
      send_lba(32'd63);
      send_lba(32'd1007);
      send_lba(32'd1008);
      send_lba(32'd1032191);
      send_lba(32'd1032192);
      send_lba(32'hFFFF_FFFE);
      send_lba(32'hFFFF_FFFF);
      wait_idle();
   endtask

   // Zero heads, zero sectors and too many heads; capacity beats geometry, geometry beats
   // the cylinder check.
   task automatic test_geometry_faults();
      set_geometry(32'd100, 32'd0, 32'd63);
      send_lba(32'd5);
      send_lba(32'd100);
      wait_idle();
      set_geometry(32'hFFFF_FFFF, 32'd16, 32'd0);
      send_lba(32'd7);
      wait_idle();
      set_geometry(32'hFFFF_FFFF, 32'd17, 32'd63);
      send_lba(32'd7);
      wait_idle();
      set_geometry(32'hFFFF_FFFF, 32'd31, 32'd255);
      send_lba(32'hF000_0000);
      wait_idle();
   endtask

   // Smallest and largest geometry at the cylinder limit; upper data bits must be dropped.
   task automatic test_geometry_extremes();
      set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFE1, 32'hFFFF_FF01);
      send_lba(32'd1023);
      send_lba(32'd1024);
      wait_idle();
      set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      send_lba(32'd4177919);
      send_lba(32'd4177920);
      send_lba(32'd4079);
      wait_idle();
   endtask

   // Pick an address: mostly inside the translatable span, some on the edges, some noise.
   function automatic logic [l2c_pkg::LBA_W-1:0] pick_lba();
      longint unsigned per_cyl;
      longint unsigned span;
      longint unsigned lim;
      int              pick;
      per_cyl = (geo_heads == 0 || geo_spt == 0) ? 64'd1 : 64'(geo_heads) * 64'(geo_spt);
      span    = per_cyl * (MAX_CYL + 1);
      lim     = (span < 64'(geo_total)) ? span : 64'(geo_total);
      pick    = $urandom_range(0, 19);
      if (pick < 12 && lim > 0) return $urandom_range(0, 32'(lim - 1));
      case (pick)
         12: return geo_total - 1;
         13: return geo_total;
         14: return 32'(span - 1);
         15: return 32'(span);
         default: return $urandom;
      endcase
   endfunction

   // Random geometry per phase, extremes first, random addresses within each phase.
   task automatic test_random_phases();
      logic [31:0] total;
      logic [31:0] heads_data;
      logic [31:0] spt_data;
      int          pick;
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 0) begin
            total = 32'hFFFF_FFFF; heads_data = 32'd16; spt_data = 32'd255;
         end else if (phase == 1) begin
            total = 32'hFFFF_FFFF; heads_data = 32'd1; spt_data = 32'd1;
         end else begin
            pick = $urandom_range(0, 9);
            heads_data = (pick == 0) ? 32'd0 :
                         (pick == 1) ? $urandom_range(17, 31) : $urandom_range(1, 16);
            pick = $urandom_range(0, 9);
            spt_data = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd255 :
                       (pick == 2) ? 32'd1 : $urandom_range(1, 255);
            // Sometimes set the unused upper data bits; the block must ignore them.
            if ($urandom_range(0, 2) == 0) begin
               heads_data = 32'({$urandom, heads_data[l2c_pkg::HC_W-1:0]});
               spt_data   = 32'({$urandom, spt_data[l2c_pkg::SECT_W-1:0]});
            end
            pick = $urandom_range(0, 9);
            total = (pick == 0) ? 32'hFFFF_FFFF : (pick == 1) ? 32'd0 :
                    (pick == 2) ? $urandom :
                    $urandom_range(1, 32'(heads_data[l2c_pkg::HC_W-1:0]) *
                                      spt_data[l2c_pkg::SECT_W-1:0] * (MAX_CYL + 1) + 1);
         end
         set_geometry(total, heads_data, spt_data);
         repeat (55) send_lba(pick_lba());
         wait_idle();
      end
   endtask

   // Hold the receiver off for a long stretch while the sender keeps offering beats, so
   // the pipeline and queue fill and the input stalls.
   task automatic test_backpressure();
      set_geometry(32'hFFFF_FFFF, 32'd16, 32'd63);
      send_gaps    = 1'b0;
      recv_stalls  = 1'b0;
      hold_request = HOLD_CYCLES;
      repeat (40) send_lba($urandom_range(0, 32'd1032191 + 100));
      wait_idle();
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_full_rate();
      set_geometry(32'd2_000_000, 32'd15, 32'd200);
      send_gaps   = 1'b0;
      recv_stalls = 1'b0;
      repeat (60) send_lba(pick_lba());
      wait_idle();
   endtask

   initial begin
      clock                        = 1'b0;
      reset                        = 1'b1;
      csr_write_enable             = 1'b0;
      csr_index                    = l2c_pkg::CSR_TOTAL_SECTORS;
      csr_write_data               = '0;
      req_if.valid                 = 1'b0;
      req_if.payload               = '0;
      geo_total                    = l2c_pkg::TOTAL_RESET;
      geo_heads                    = l2c_pkg::HEAD_COUNT_RESET;
      geo_spt                      = l2c_pkg::SPT_RESET;
      send_gaps                    = 1'b1;
      recv_stalls                  = 1'b1;

      // Hold reset, then release it at a falling edge.
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_geometry();
      test_geometry_faults();
      test_geometry_extremes();
      test_random_phases();
      test_backpressure();
      test_full_rate();

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/l2c_pkg.sv
sv/l2c_stream_if.sv
sv/l2c_front.sv
sv/l2c_queue.sv
sv/l2c_back.sv
sv/lba_to_chs_translator_top.sv
tb/sv/testbench.sv
